// ===== design/csvfs_pkg.sv =====
`default_nettype none

package csvfs_pkg;

    localparam int unsigned MAX_COLUMNS = 256;
    localparam longint unsigned MAX_ROWS = 64'd65536;

    localparam logic [7:0] COL_TOP =
        8'((MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1);
    localparam logic [15:0] ROW_TOP =
        16'((MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1);

    localparam logic [7:0] QUOTE_BYTE = 8'd34;
    localparam logic [7:0] COMMA_BYTE = 8'd44;
    localparam logic [7:0] LF_BYTE    = 8'd10;
    localparam logic [7:0] CR_BYTE    = 8'd13;
    localparam logic [7:0] END_BYTE   = 8'd0;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_FIELD_END = 3'd1,
        KIND_REC_END   = 3'd2,
        KIND_ERROR     = 3'd3,
        KIND_DOC_END   = 3'd4
    } t_kind;

endpackage

`default_nettype wire

// ===== design/csv_field_splitter_top.sv =====
// csv field splitter: one document byte in, at most one result out
// a byte accepted into the input register feeds the parse logic, which writes its result
// into the result register when the output can take it
// throughput: one byte per cycle, limited only by output backpressure
// reset: synchronous active low; clears the parse state and the valid flags of both
// register stages, and sets cr_is_newline to 1
`default_nettype none

module csv_field_splitter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_data,
    output logic [7:0]       o_column,
    output logic [15:0]      o_row,
    output logic             o_done_res
);

    logic        r_cr_is_newline;

    logic        r_in_valid;
    logic [7:0]  r_ch;

    logic        r_in_quotes,      n_in_quotes;
    logic        r_after_quote,    n_after_quote;
    logic        r_close_pending,  n_close_pending;
    logic        r_in_newline_run, n_in_newline_run;
    logic        r_at_start,       n_at_start;
    logic        r_failed,         n_failed;
    logic [7:0]  r_column,         n_column;
    logic [15:0] r_row,            n_row;

    logic                r_out_valid;
    csvfs_pkg::t_kind    r_kind, n_kind;
    logic [7:0]          r_data, n_data;
    logic [7:0]          r_out_column;
    logic [15:0]         r_out_row;
    logic                r_done, n_done;
    logic                n_has_result;

    logic advance;
    logic is_quote;
    logic is_newline;
    logic is_end;
    logic check;
    logic inq;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    assign is_quote   = (r_ch == csvfs_pkg::QUOTE_BYTE);
    assign is_end     = (r_ch == csvfs_pkg::END_BYTE);
    assign is_newline = (r_ch == csvfs_pkg::LF_BYTE) ||
                        (r_cr_is_newline && (r_ch == csvfs_pkg::CR_BYTE));

    // quote handling: the byte after an opening or closing quote is never a quote delimiter
    assign check = !r_close_pending && !r_after_quote;
    assign inq   = r_close_pending ? 1'b1 : r_in_quotes;

    always_comb begin
        n_in_quotes      = r_in_quotes;
        n_after_quote    = r_after_quote;
        n_close_pending  = r_close_pending;
        n_in_newline_run = r_in_newline_run;
        n_at_start       = r_at_start;
        n_failed         = r_failed;
        n_column         = r_column;
        n_row            = r_row;
        n_has_result     = 1'b0;
        n_kind           = csvfs_pkg::KIND_DATA;
        n_data           = 8'd0;
        n_done           = 1'b0;

        if (r_failed) begin
            if (is_end) begin
                n_has_result = 1'b1;
                n_kind       = csvfs_pkg::KIND_ERROR;
                n_done       = 1'b1;
            end
        end else if (is_end && r_at_start) begin
            n_has_result = 1'b1;
            n_kind       = csvfs_pkg::KIND_ERROR;
            n_done       = 1'b1;
        end else begin
            n_at_start    = 1'b0;
            n_after_quote = 1'b0;
            n_close_pending = 1'b0;
            if (r_close_pending && is_quote) begin
                // doubled quote inside a quoted run
                n_has_result = 1'b1;
                n_kind       = csvfs_pkg::KIND_DATA;
                n_data       = csvfs_pkg::QUOTE_BYTE;
            end else begin
                if (r_close_pending) begin
                    n_in_quotes = 1'b0;
                end
                if (check && is_quote) begin
                    n_in_newline_run = 1'b0;
                    if (!r_in_quotes) begin
                        n_in_quotes   = 1'b1;
                        n_after_quote = 1'b1;
                    end else begin
                        n_close_pending = 1'b1;
                    end
                end else if (is_newline || is_end) begin
                    if (inq && !r_close_pending) begin
                        n_has_result = 1'b1;
                        n_kind       = csvfs_pkg::KIND_ERROR;
                        if (is_end) begin
                            n_done = 1'b1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (is_end) begin
                        n_has_result = 1'b1;
                        n_kind       = r_in_newline_run ? csvfs_pkg::KIND_DOC_END
                                                        : csvfs_pkg::KIND_REC_END;
                        n_done       = 1'b1;
                    end else if (!r_in_newline_run) begin
                        n_has_result     = 1'b1;
                        n_kind           = csvfs_pkg::KIND_REC_END;
                        n_in_newline_run = 1'b1;
                        n_column         = 8'd0;
                        if (r_row < csvfs_pkg::ROW_TOP) begin
                            n_row = r_row + 16'd1;
                        end
                    end
                end else begin
                    n_in_newline_run = 1'b0;
                    n_has_result     = 1'b1;
                    if (!(inq && !r_close_pending) &&
                        (r_ch == csvfs_pkg::COMMA_BYTE)) begin
                        n_kind = csvfs_pkg::KIND_FIELD_END;
                        if (r_column < csvfs_pkg::COL_TOP) begin
                            n_column = r_column + 8'd1;
                        end
                    end else begin
                        n_kind = csvfs_pkg::KIND_DATA;
                        n_data = r_ch;
                    end
                end
            end
        end

        // end of document returns the parser to its start state
        if (n_done) begin
            n_in_quotes      = 1'b0;
            n_after_quote    = 1'b0;
            n_close_pending  = 1'b0;
            n_in_newline_run = 1'b0;
            n_at_start       = 1'b1;
            n_failed         = 1'b0;
            n_column         = 8'd0;
            n_row            = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_is_newline <= 1'b1;
        end else if (i_cfg_we) begin
            r_cr_is_newline <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes      <= 1'b0;
            r_after_quote    <= 1'b0;
            r_close_pending  <= 1'b0;
            r_in_newline_run <= 1'b0;
            r_at_start       <= 1'b1;
            r_failed         <= 1'b0;
            r_column         <= 8'd0;
            r_row            <= 16'd0;
        end else if (advance) begin
            r_in_quotes      <= n_in_quotes;
            r_after_quote    <= n_after_quote;
            r_close_pending  <= n_close_pending;
            r_in_newline_run <= n_in_newline_run;
            r_at_start       <= n_at_start;
            r_failed         <= n_failed;
            r_column         <= n_column;
            r_row            <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_has_result;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind       <= n_kind;
            r_data       <= n_data;
            r_out_column <= r_column;
            r_out_row    <= r_row;
            r_done       <= n_done;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_data     = r_data;
    assign o_column   = r_out_column;
    assign o_row      = r_out_row;
    assign o_done_res = r_done;

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |->
            (o_kind == csvfs_pkg::KIND_ERROR) || (o_kind == csvfs_pkg::KIND_REC_END) ||
            (o_kind == csvfs_pkg::KIND_DOC_END))
        else $error("done flag on a non-final kind");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != csvfs_pkg::KIND_DATA) |-> (o_data == 8'd0))
        else $error("nonzero data on a non-data item");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_done |=> r_at_start && !r_failed && !r_in_quotes &&
            (r_column == 8'd0) && (r_row == 16'd0))
        else $error("parse state not cleared after document end");

    a_quote_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_close_pending && r_after_quote))
        else $error("close pending and after quote both set");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        csvfs_pkg::t_kind kind;
        logic [7:0]       data;
        logic [7:0]       column;
        logic [15:0]      row;
        logic             done;
    } t_split_res;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_ch       = 8'd0;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [7:0]  o_data;
    logic [7:0]  o_column;
    logic [15:0] o_row;
    logic        o_done_res;

    logic [7:0]  doc_bytes_q[$];
    t_split_res  split_q[$];
    int          bytes_pushed   = 0;
    int          bytes_accepted = 0;
    int          err_cnt        = 0;
    int          idle_cycles    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    // predictor state
    bit          cr_newline     = 1'b1;
    bit          st_in_quotes;
    bit          st_after_quote;
    bit          st_close_pend;
    bit          st_nl_run;
    bit          st_at_start;
    bit          st_failed;
    logic [7:0]  col_cnt;
    logic [15:0] row_cnt;

    csv_field_splitter_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_ch       (i_ch),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_data     (o_data),
        .o_column   (o_column),
        .o_row      (o_row),
        .o_done_res (o_done_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_doc();
        st_in_quotes   = 1'b0;
        st_after_quote = 1'b0;
        st_close_pend  = 1'b0;
        st_nl_run      = 1'b0;
        st_at_start    = 1'b1;
        st_failed      = 1'b0;
        col_cnt        = 8'd0;
        row_cnt        = 16'd0;
    endfunction

    function automatic t_split_res make_res(csvfs_pkg::t_kind k, logic [7:0] d, bit dn);
        t_split_res r;
        r.kind   = k;
        r.data   = d;
        r.column = col_cnt;
        r.row    = row_cnt;
        r.done   = dn;
        if (dn) begin
            clear_doc();
        end
        return r;
    endfunction

    function automatic bit split_byte(input logic [7:0] b, output t_split_res r);
        bit chk;
        bit nl;
        chk = 1'b1;
        if (st_failed) begin
            if (b == csvfs_pkg::END_BYTE) begin
                r = make_res(csvfs_pkg::KIND_ERROR, 8'd0, 1'b1);
                return 1'b1;
            end
            return 1'b0;
        end
        if (b == csvfs_pkg::END_BYTE && st_at_start) begin
            r = make_res(csvfs_pkg::KIND_ERROR, 8'd0, 1'b1);
            return 1'b1;
        end
        st_at_start = 1'b0;
        if (st_close_pend) begin
            st_close_pend = 1'b0;
            if (b == csvfs_pkg::QUOTE_BYTE) begin
                r = make_res(csvfs_pkg::KIND_DATA, csvfs_pkg::QUOTE_BYTE, 1'b0);
                return 1'b1;
            end
            st_in_quotes = 1'b0;
            chk = 1'b0;
        end else if (st_after_quote) begin
            st_after_quote = 1'b0;
            chk = 1'b0;
        end
        if (chk && b == csvfs_pkg::QUOTE_BYTE) begin
            st_nl_run = 1'b0;
            if (!st_in_quotes) begin
                st_in_quotes   = 1'b1;
                st_after_quote = 1'b1;
            end else begin
                st_close_pend = 1'b1;
            end
            return 1'b0;
        end
        nl = (b == csvfs_pkg::LF_BYTE) || (cr_newline && b == csvfs_pkg::CR_BYTE);
        if (nl || b == csvfs_pkg::END_BYTE) begin
            if (st_in_quotes) begin
                if (b == csvfs_pkg::END_BYTE) begin
                    r = make_res(csvfs_pkg::KIND_ERROR, 8'd0, 1'b1);
                    return 1'b1;
                end
                r = make_res(csvfs_pkg::KIND_ERROR, 8'd0, 1'b0);
                st_failed = 1'b1;
                return 1'b1;
            end
            if (b == csvfs_pkg::END_BYTE) begin
                r = make_res(st_nl_run ? csvfs_pkg::KIND_DOC_END : csvfs_pkg::KIND_REC_END,
                             8'd0, 1'b1);
                return 1'b1;
            end
            if (st_nl_run) begin
                return 1'b0;
            end
            r = make_res(csvfs_pkg::KIND_REC_END, 8'd0, 1'b0);
            st_nl_run = 1'b1;
            col_cnt = 8'd0;
            if (row_cnt < csvfs_pkg::ROW_TOP) begin
                row_cnt = row_cnt + 16'd1;
            end
            return 1'b1;
        end
        st_nl_run = 1'b0;
        if (!st_in_quotes && b == csvfs_pkg::COMMA_BYTE) begin
            r = make_res(csvfs_pkg::KIND_FIELD_END, 8'd0, 1'b0);
            if (col_cnt < csvfs_pkg::COL_TOP) begin
                col_cnt = col_cnt + 8'd1;
            end
            return 1'b1;
        end
        r = make_res(csvfs_pkg::KIND_DATA, b, 1'b0);
        return 1'b1;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_split_res res;
        bit has_res;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                has_res = split_byte(i_ch, res);
                if (has_res) begin
                    split_q = {split_q, res};
                end
                bytes_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (doc_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_ch    <= doc_bytes_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_split_res exp_res;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (split_q.size() == 0) begin
                    $error("result with no item pending: kind %0d data %0d", o_kind, o_data);
                    err_cnt++;
                end else begin
                    exp_res = split_q.pop_front();
                    if (o_kind !== exp_res.kind) begin
                        $error("kind: expected %0d, actual %0d", exp_res.kind, o_kind);
                        err_cnt++;
                    end
                    if (o_data !== exp_res.data) begin
                        $error("data: expected %0d, actual %0d", exp_res.data, o_data);
                        err_cnt++;
                    end
                    if (o_column !== exp_res.column) begin
                        $error("column: expected %0d, actual %0d", exp_res.column, o_column);
                        err_cnt++;
                    end
                    if (o_row !== exp_res.row) begin
                        $error("row: expected %0d, actual %0d", exp_res.row, o_row);
                        err_cnt++;
                    end
                    if (o_done_res !== exp_res.done) begin
                        $error("done_res: expected %0d, actual %0d", exp_res.done, o_done_res);
                        err_cnt++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_byte(logic [7:0] b);
        doc_bytes_q = {doc_bytes_q, b};
        bytes_pushed++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == csvfs_pkg::QUOTE_BYTE || b == csvfs_pkg::COMMA_BYTE ||
               b == csvfs_pkg::LF_BYTE || b == csvfs_pkg::CR_BYTE) begin
            b = 8'($urandom_range(1, 255));
        end
        return b;
    endfunction

    task automatic gen_newline();
        case ($urandom_range(0, 4))
            0: push_byte(csvfs_pkg::LF_BYTE);
            1: push_byte(csvfs_pkg::CR_BYTE);
            2: begin
                push_byte(csvfs_pkg::CR_BYTE);
                push_byte(csvfs_pkg::LF_BYTE);
            end
            3: begin
                push_byte(csvfs_pkg::LF_BYTE);
                push_byte(csvfs_pkg::LF_BYTE);
            end
            default: begin
                push_byte(csvfs_pkg::CR_BYTE);
                push_byte(csvfs_pkg::CR_BYTE);
                push_byte(csvfs_pkg::LF_BYTE);
            end
        endcase
    endtask

    task automatic gen_field();
        int n;
        int sel;
        n   = $urandom_range(0, 5);
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            repeat (n) push_byte(plain_byte());
        end else if (sel < 95) begin
            push_byte(csvfs_pkg::QUOTE_BYTE);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0: begin
                        push_byte(csvfs_pkg::QUOTE_BYTE);
                        push_byte(csvfs_pkg::QUOTE_BYTE);
                    end
                    1: push_byte(csvfs_pkg::COMMA_BYTE);
                    default: push_byte(plain_byte());
                endcase
            end
            push_byte(csvfs_pkg::QUOTE_BYTE);
            if ($urandom_range(0, 9) == 0) begin
                push_byte(plain_byte());
            end
        end else begin
            // broken quoted field
            push_byte(csvfs_pkg::QUOTE_BYTE);
            push_byte($urandom_range(0, 1) ? csvfs_pkg::LF_BYTE : csvfs_pkg::CR_BYTE);
            repeat (n) push_byte(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic gen_doc();
        int rows;
        int cols;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            push_byte(csvfs_pkg::END_BYTE);
        end else if (sel < 14) begin
            repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(1, 255)));
            push_byte(csvfs_pkg::END_BYTE);
        end else begin
            rows = $urandom_range(1, 4);
            for (int r = 0; r < rows; r++) begin
                cols = $urandom_range(1, 4);
                for (int c = 0; c < cols; c++) begin
                    if (c != 0) begin
                        push_byte(csvfs_pkg::COMMA_BYTE);
                    end
                    gen_field();
                end
                if (r < rows - 1 || $urandom_range(0, 1)) begin
                    gen_newline();
                end
            end
            push_byte(csvfs_pkg::END_BYTE);
        end
    endtask

    task automatic write_cfg(bit v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cr_newline = v;
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_pushed || split_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] dir_bytes [24];
        int start_cnt;
        dir_bytes = '{
            csvfs_pkg::END_BYTE,
            "a", csvfs_pkg::COMMA_BYTE, csvfs_pkg::QUOTE_BYTE, "x",
            csvfs_pkg::QUOTE_BYTE, csvfs_pkg::QUOTE_BYTE, "y", csvfs_pkg::QUOTE_BYTE,
            csvfs_pkg::COMMA_BYTE, csvfs_pkg::CR_BYTE, csvfs_pkg::LF_BYTE, 8'd255,
            csvfs_pkg::END_BYTE,
            csvfs_pkg::QUOTE_BYTE, csvfs_pkg::QUOTE_BYTE, csvfs_pkg::LF_BYTE,
            csvfs_pkg::END_BYTE,
            "z", csvfs_pkg::LF_BYTE, csvfs_pkg::END_BYTE,
            csvfs_pkg::QUOTE_BYTE, "a", csvfs_pkg::END_BYTE
        };
        clear_doc();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 60;
        write_cfg(1'b1);
        foreach (dir_bytes[i]) push_byte(dir_bytes[i]);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_cfg(ph % 2 == 1);
            start_cnt = bytes_pushed;
            if (ph == 1) begin
                // column saturation
                repeat (260) begin
                    push_byte(plain_byte());
                    push_byte(csvfs_pkg::COMMA_BYTE);
                end
                push_byte(csvfs_pkg::END_BYTE);
            end
            while (bytes_pushed - start_cnt < 230) gen_doc();
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (split_q.size() != 0) begin
            $error("%0d expected results never arrived", split_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
